// ===== hw/rtl/nested_tag_validator_core_defines.svh =====
// Assertion macros shared by the nested tag validator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef NESTED_TAG_VALIDATOR_CORE_DEFINES_SVH
`define NESTED_TAG_VALIDATOR_CORE_DEFINES_SVH
`ifndef SYNTH
`define NTV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NTV_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NTV_ASSERT(label, clk, rst_n, prop, msg)
`define NTV_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/ntv_pkg.sv =====
// Shared types and constants of the nested tag validator.
// No dependencies; imported by every module of the block.
package ntv_pkg;

    localparam int CDATA_LEN   = 9;
    localparam int BANG_POS    = 2;
    localparam int CLOSE_RUN   = 2;
    localparam int MARK_W      = 4;
    localparam int LETTER_W    = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_Z      = 8'h5A;

    localparam logic [7:0] CDATA_OPENER [CDATA_LEN] = '{
        8'h3C, 8'h21, 8'h5B, 8'h43, 8'h44, 8'h41, 8'h54, 8'h41, 8'h5B
    };

    typedef enum logic [7:0] {
        PH_START      = 8'b0000_0001,
        PH_LT         = 8'b0000_0010,
        PH_OPEN_NAME  = 8'b0000_0100,
        PH_CLOSE_NAME = 8'b0000_1000,
        PH_CONTENT    = 8'b0001_0000,
        PH_CDATA_OPEN = 8'b0010_0000,
        PH_CDATA_BODY = 8'b0100_0000,
        PH_DONE       = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic                 is_upper;
        logic [LETTER_W-1:0]  letter;
        logic                 is_lt;
        logic                 is_gt;
        logic                 is_slash;
        logic                 is_bang;
        logic                 is_rbrack;
        logic [CDATA_LEN-1:0] cdata_hit;
        logic                 last;
    } token_t;

endpackage

// ===== hw/rtl/ntv_front.sv =====
// Front end: classifies each incoming byte into a token word.
// Depends on ntv_pkg.
module ntv_front (
    input  logic          [7:0] symbol,
    input  logic                last_symbol,
    output ntv_pkg::token_t     token
);
    import ntv_pkg::*;

    logic [7:0] letter_off;

    assign letter_off = symbol - CH_A + 8'd1;

    always_comb
    begin
        token          = '0;
        token.is_upper = (symbol >= CH_A) && (symbol <= CH_Z);
        token.letter   = letter_off[LETTER_W-1:0];
        token.is_lt    = (symbol == CH_LT);
        token.is_gt    = (symbol == CH_GT);
        token.is_slash = (symbol == CH_SLASH);
        token.is_bang  = (symbol == CH_BANG);
        token.is_rbrack = (symbol == CH_RBRACK);
        for (int i = 0; i < CDATA_LEN; i++)
        begin
            token.cdata_hit[i] = (symbol == CDATA_OPENER[i]);
        end
        token.last = last_symbol;
    end

endmodule

// ===== hw/rtl/ntv_queue.sv =====
// Short token queue between the classifier and the parser.
// Depends on ntv_pkg.
module ntv_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  ntv_pkg::token_t wr_token,
    output logic            rd_valid,
    input  logic            rd_pop,
    output ntv_pkg::token_t rd_token
);
    import ntv_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    token_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_token = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_token;
        end
    end

endmodule

// ===== hw/rtl/ntv_back.sv =====
// Back end: tag parser with open-name stack and verdict register.
// Depends on ntv_pkg and nested_tag_validator_core_defines.svh.
`include "nested_tag_validator_core_defines.svh"

module ntv_back #(
    parameter int MAX_DEPTH    = 16,
    parameter int MAX_NAME_LEN = 9
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  ntv_pkg::token_t head_token,
    output logic            head_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            document_valid
);
    import ntv_pkg::*;

    localparam int LET_W   = LETTER_W * MAX_NAME_LEN;
    localparam int LEN_W   = $clog2(MAX_NAME_LEN + 1);
    localparam int FILL_W  = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int ENTRY_W = LET_W + LEN_W;

    logic [ENTRY_W-1:0] stack_mem [1 << ADDR_W];
    logic [ENTRY_W-1:0] top_reg;

    phase_t             phase_reg, phase_next;
    logic [FILL_W-1:0]  fill_reg, fill_next, fill_m1;
    logic [LET_W-1:0]   letters_reg, letters_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [MARK_W-1:0]  marker_reg, marker_next;
    logic               failed_reg, failed_next;
    logic               root_reg, root_next;
    logic               out_valid_reg, out_valid_next;
    logic               verdict_reg, verdict;
    logic               take, take_last, ok, push, len_full;

    assign take      = head_valid && (!head_token.last || !out_valid_reg || out_ready);
    assign take_last = take && head_token.last;
    assign head_pop  = take;
    assign fill_m1   = fill_reg - FILL_W'(1);
    assign len_full  = (len_reg >= LEN_W'(MAX_NAME_LEN));

    always_comb
    begin
        phase_next   = phase_reg;
        fill_next    = fill_reg;
        letters_next = letters_reg;
        len_next     = len_reg;
        marker_next  = marker_reg;
        failed_next  = failed_reg;
        root_next    = root_reg;
        push         = 1'b0;
        ok           = 1'b1;
        verdict      = 1'b0;
        if (take && !failed_reg)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (head_token.is_lt)
                    begin
                        phase_next = PH_LT;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
                PH_LT:
                begin
                    if (head_token.is_upper)
                    begin
                        letters_next = LET_W'(head_token.letter);
                        len_next     = LEN_W'(1);
                        phase_next   = PH_OPEN_NAME;
                    end
                    else if (fill_reg == '0)
                    begin
                        ok = 1'b0;
                    end
                    else if (head_token.is_slash)
                    begin
                        letters_next = '0;
                        len_next     = '0;
                        phase_next   = PH_CLOSE_NAME;
                    end
                    else if (head_token.is_bang)
                    begin
                        marker_next = MARK_W'(BANG_POS);
                        phase_next  = PH_CDATA_OPEN;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
                PH_OPEN_NAME:
                begin
                    if (head_token.is_upper)
                    begin
                        if (len_full)
                        begin
                            ok = 1'b0;
                        end
                        else
                        begin
                            letters_next = (letters_reg << LETTER_W) | LET_W'(head_token.letter);
                            len_next     = len_reg + LEN_W'(1);
                        end
                    end
                    else if (!head_token.is_gt || len_reg == '0
                             || fill_reg >= FILL_W'(MAX_DEPTH))
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        push       = 1'b1;
                        fill_next  = fill_reg + FILL_W'(1);
                        phase_next = PH_CONTENT;
                    end
                end
                PH_CLOSE_NAME:
                begin
                    if (head_token.is_upper)
                    begin
                        if (len_full)
                        begin
                            ok = 1'b0;
                        end
                        else
                        begin
                            letters_next = (letters_reg << LETTER_W) | LET_W'(head_token.letter);
                            len_next     = len_reg + LEN_W'(1);
                        end
                    end
                    else if (!head_token.is_gt || len_reg == '0 || fill_reg == '0
                             || top_reg != {letters_reg, len_reg})
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        fill_next = fill_m1;
                        if (fill_m1 == '0)
                        begin
                            root_next  = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_CONTENT;
                        end
                    end
                end
                PH_CONTENT:
                begin
                    if (head_token.is_lt)
                    begin
                        phase_next = PH_LT;
                    end
                end
                PH_CDATA_OPEN:
                begin
                    if (marker_reg >= MARK_W'(CDATA_LEN) || !head_token.cdata_hit[marker_reg])
                    begin
                        ok = 1'b0;
                    end
                    else if (marker_reg == MARK_W'(CDATA_LEN - 1))
                    begin
                        marker_next = '0;
                        phase_next  = PH_CDATA_BODY;
                    end
                    else
                    begin
                        marker_next = marker_reg + MARK_W'(1);
                    end
                end
                PH_CDATA_BODY:
                begin
                    if (head_token.is_rbrack)
                    begin
                        if (marker_reg < MARK_W'(CLOSE_RUN))
                        begin
                            marker_next = marker_reg + MARK_W'(1);
                        end
                    end
                    else if (head_token.is_gt && marker_reg == MARK_W'(CLOSE_RUN))
                    begin
                        marker_next = '0;
                        phase_next  = PH_CONTENT;
                    end
                    else
                    begin
                        marker_next = '0;
                    end
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
            if (!ok)
            begin
                failed_next = 1'b1;
            end
        end
        if (take_last)
        begin
            verdict      = !failed_next && root_next && (phase_next == PH_DONE);
            phase_next   = PH_START;
            fill_next    = '0;
            letters_next = '0;
            len_next     = '0;
            marker_next  = '0;
            failed_next  = 1'b0;
            root_next    = 1'b0;
            push         = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take_last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            fill_reg      <= '0;
            letters_reg   <= '0;
            len_reg       <= '0;
            marker_reg    <= '0;
            failed_reg    <= 1'b0;
            root_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            fill_reg      <= fill_next;
            letters_reg   <= letters_next;
            len_reg       <= len_next;
            marker_reg    <= marker_next;
            failed_reg    <= failed_next;
            root_reg      <= root_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_last)
        begin
            verdict_reg <= verdict;
        end
    end

    // read the stack top every cycle; a close name always spans more than one word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[fill_reg[ADDR_W-1:0]] <= {letters_reg, len_reg};
        end
        top_reg <= stack_mem[fill_m1[ADDR_W-1:0]];
    end

    assign out_valid      = out_valid_reg;
    assign document_valid = verdict_reg;

    `NTV_ASSERT_ALWAYS(a_fill_bound, clk, fill_reg <= FILL_W'(MAX_DEPTH), "stack fill out of range")
    `NTV_ASSERT(a_len_bound, clk, rst_n, len_reg <= LEN_W'(MAX_NAME_LEN), "name too long")
    `NTV_ASSERT(a_done_empty, clk, rst_n, (phase_reg == PH_DONE) |-> (fill_reg == '0 && root_reg), "done with open names")
    `NTV_ASSERT(a_body_run, clk, rst_n, (phase_reg == PH_CDATA_BODY) |-> (marker_reg <= MARK_W'(CLOSE_RUN)), "cdata close run overrun")
    `NTV_ASSERT(a_verdict_src, clk, rst_n, $rose(out_valid_reg) |-> $past(take_last), "verdict without last word")

endmodule

// ===== hw/rtl/nested_tag_validator_core.sv =====
// Top level of the nested tag validator.
// Depends on ntv_pkg, ntv_front, ntv_queue and ntv_back.
//
// Streams a document one byte per cycle while the queue has room and, on the
// byte flagged last, returns one verdict: 1 when the whole document is a single
// closed tag (nested tags, text and CDATA sections allowed inside), else 0. No
// result is produced for other bytes. A classifier feeds a two-word queue; the
// parser drains it at one byte per cycle, save that a last byte waits while an
// earlier verdict is untaken, limited by its registered state update and one
// stack read a cycle. The verdict is registered in the cycle after the parser
// takes the last byte and sits in an output register, so bytes of the next
// document keep flowing while it waits; only the next last byte holds until
// the verdict is taken. All parser state returns to reset after the verdict.
module nested_tag_validator_core #(
    parameter int MAX_DEPTH    = 16,
    parameter int MAX_NAME_LEN = 9
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] symbol,
    input  logic       last_symbol,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       document_valid
);
    import ntv_pkg::*;

    token_t in_token;
    token_t head_token;
    logic   head_valid;
    logic   head_pop;

    ntv_front u_front (
        .symbol      (symbol),
        .last_symbol (last_symbol),
        .token       (in_token)
    );

    ntv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_ready (in_ready),
        .wr_token (in_token),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_token (head_token)
    );

    ntv_back #(
        .MAX_DEPTH    (MAX_DEPTH),
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_token     (head_token),
        .head_pop       (head_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .document_valid (document_valid)
    );

endmodule
